FILE: rtl/isort_pkg.sv
// shared types, constants and helpers for the insertion sorter
package isort_pkg;

   localparam int KEY_W        = 32;
   localparam int MAX_KEYS_DEF = 64;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic insert;
      logic shift_out;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic last_key;
   } status_type;

   // signed less-than on raw key patterns
   function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

endpackage

FILE: rtl/isort_ifs.sv
// valid/ready channel interfaces for keys in and sorted keys out
interface isort_req_if
   import isort_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_value;
   logic             final_key;

   modport source (output valid, output key_value, output final_key, input ready);
   modport sink (input valid, input key_value, input final_key, output ready);
endinterface

interface isort_rsp_if
   import isort_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] sorted_key;
   logic             end_of_set;
   logic             keys_dropped;

   modport source (output valid, output sorted_key, output end_of_set, output keys_dropped,
                   input ready);
   modport sink (input valid, input sorted_key, input end_of_set, input keys_dropped,
                 output ready);
endinterface

FILE: rtl/isort_ctrl.sv
// controller: load phase takes keys, drain phase emits the sorted set
module isort_ctrl
   import isort_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_final,
   input  logic       rsp_ready,
   input  status_type status,
   output logic       req_ready,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      req_xfer;
   logic      rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_xfer && req_final) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_xfer && status.last_key) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.insert    = 1'b0;
      cmd.shift_out = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready  = 1'b1;
            cmd.insert = req_valid;
         end
         ST_DRAIN: begin
            rsp_valid     = 1'b1;
            cmd.shift_out = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/isort_dpath.sv
// datapath: row of compare-and-shift cells holding the keys in ascending order
module isort_dpath
   import isort_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [KEY_W-1:0] key_value,
   output status_type       status,
   output logic [KEY_W-1:0] head_key,
   output logic             overflow
);

   localparam int CNT_W = $clog2(MAX_KEYS + 1);

   logic [KEY_W-1:0] store_ff [MAX_KEYS];
   logic [KEY_W-1:0] store_in [MAX_KEYS];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             overflow_ff;
   logic             overflow_in;
   logic [MAX_KEYS-1:0] opened;
   logic             full;
   logic             do_insert;

   assign full      = (count_ff == CNT_W'(MAX_KEYS));
   assign do_insert = cmd.insert && !full;

   // a cell opens if its key is greater than the new one, or it is the first free slot
   for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
      logic [KEY_W-1:0] below_key;
      logic             below_open;
      logic [KEY_W-1:0] above_key;

      assign opened[g] = (CNT_W'(g) == count_ff) ||
                         ((CNT_W'(g) < count_ff) && key_less(key_value, store_ff[g]));

      if (g == 0) begin : g_bottom
         assign below_open = 1'b0;
         assign below_key  = key_value;
      end else begin : g_upper
         assign below_open = opened[g-1];
         assign below_key  = store_ff[g-1];
      end

      // the top cell keeps its key on a shift out
      if (g == MAX_KEYS - 1) begin : g_top
         assign above_key = store_ff[g];
      end else begin : g_lower
         assign above_key = store_ff[g+1];
      end

      always_comb begin
         store_in[g] = store_ff[g];
         if (do_insert && opened[g]) begin
            store_in[g] = below_open ? below_key : key_value;
         end else if (cmd.shift_out) begin
            store_in[g] = above_key;
         end
      end

      always_ff @(posedge clock) begin
         store_ff[g] <= store_in[g];
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.insert) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (cmd.shift_out) begin
         count_in = count_ff - CNT_W'(1);
         if (status.last_key) begin
            overflow_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   assign status.last_key = (count_ff == CNT_W'(1));
   assign head_key        = store_ff[0];
   assign overflow        = overflow_ff;

endmodule

FILE: rtl/insertion_sorter.sv
// Stable insertion sorter for signed 32-bit keys. Keys enter on req_ch one per cycle while the
// block is loading; each is placed into a row of MAX_KEYS compare-and-shift cells as it is
// taken, and equal keys keep their arrival order. A key flagged final_key ends the set: req_ch
// then stalls and the set leaves on rsp_ch in ascending order, one key per cycle when the sink
// is ready, end_of_set on the last one. Keys arriving with the store full are dropped (a final
// key still ends the set) and keys_dropped is then high on every result of that set. Reset
// clears the key count, the dropped flag and the controller state; the key store itself is not
// cleared.
module insertion_sorter
   import isort_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   isort_req_if.sink         req_ch,
   isort_rsp_if.source       rsp_ch
);

   cmd_type    cmd;
   status_type status;

   isort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_final (req_ch.final_key),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   isort_dpath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .key_value (req_ch.key_value),
      .status    (status),
      .head_key  (rsp_ch.sorted_key),
      .overflow  (rsp_ch.keys_dropped)
   );

   assign rsp_ch.end_of_set = status.last_key;

   // never take a key while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input accepted during drain");

   // a final key starts the drain next cycle
   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.final_key) |=> rsp_ch.valid)
      else $error("final key did not start output");

   // after the last result the block is loading again
   a_end_reloads: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.end_of_set) |=> (!rsp_ch.valid && req_ch.ready))
      else $error("block did not return to load after end of set");

   // the dropped flag holds across one set
   a_drop_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !(rsp_ch.ready && rsp_ch.end_of_set)) |=> $stable(rsp_ch.keys_dropped))
      else $error("keys_dropped changed within a set");

endmodule
